// File: rtl/asf_pkg.sv
// Shared types and constants for the ADC sample sort filter.
// No dependencies.
`default_nettype none

package asf_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned VoltW = 19;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSampleCount = 2'd0,
    CfgFilterMode  = 2'd1,
    CfgGainSelect  = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StIns,
    StCmp,
    StPost,
    StLo,
    StHi,
    StFilt,
    StAvg,
    StDiv,
    StOut
  } state_e;

  // Code scaled to 7.8125 uV units: code << (3 - gain).
  function automatic logic [VoltW-1:0] to_volts(input logic [CodeW-1:0] code,
                                                input logic [1:0] gain);
    logic [VoltW-1:0] ext;
    ext = {{(VoltW - CodeW){code[CodeW-1]}}, code};
    return ext << (~gain);
  endfunction

endpackage

`default_nettype wire

// File: rtl/adc_sample_sort_filter.sv
// Top level of the ADC sample sort filter: sorted sample store, min/max,
// median or trimmed running average, voltage scaling. Uses asf_pkg.
`default_nettype none

// One sample is taken per transaction (start high while busy is low). It is
// decoded as two's complement and insertion-sorted into a single-port-style
// synchronous store, one compare-and-shift step at a time, with busy high
// until the insertion is done. When the batch is complete, the store is read
// for minimum, maximum and the filtered value. The trimmed average runs a
// bit-serial divider, after a setup step, for each averaged sample, which
// lengthens a batch end in average mode. The result appears for one cycle
// with done_o high and cannot be held off.

module adc_sample_sort_filter #(
  parameter int unsigned MAX_SAMPLES = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire  [15:0]                        raw_sample_i,
  input  wire                                cfg_we_i,
  input  wire  [asf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [asf_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                               done_o,
  output logic signed [15:0]                 filtered_code_o,
  output logic signed [15:0]                 min_code_o,
  output logic signed [15:0]                 max_code_o,
  output logic signed [18:0]                 voltage_o,
  output logic signed [18:0]                 min_voltage_o,
  output logic signed [18:0]                 max_voltage_o
);

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned CodeW = asf_pkg::CodeW;

  // Configuration registers.
  logic [4:0] sample_count_q;
  logic       filter_mode_q;
  logic [1:0] gain_select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= 5'd1;
      filter_mode_q  <= 1'b0;
      gain_select_q  <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (asf_pkg::cfg_idx_e'(cfg_index_i))
        asf_pkg::CfgSampleCount: sample_count_q <= cfg_data_i;
        asf_pkg::CfgFilterMode:  filter_mode_q  <= cfg_data_i[0];
        asf_pkg::CfgGainSelect:  gain_select_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] target;
  always_comb begin
    if (sample_count_q == 5'd0) begin
      target = CW'(1);
    end else if (int'(sample_count_q) > int'(MAX_SAMPLES)) begin
      target = CW'(MAX_SAMPLES);
    end else begin
      target = CW'(sample_count_q);
    end
  end

  // Sample store.
  logic [CodeW-1:0] mem [MAX_SAMPLES];
  logic [CodeW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    waddr, raddr;
  logic [CodeW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  asf_pkg::state_e state_q, state_d;
  logic [CW-1:0]    held_q, held_d;
  logic [CW-1:0]    m_q, m_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [CodeW-1:0] lo_q, lo_d, hi_q, hi_d, filt_q, filt_d;
  logic [CodeW-1:0] dq_q, dq_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [3:0]       bit_q, bit_d;
  logic             neg_q, neg_d;

  logic             accept;
  logic [CW-1:0]    held_inc;
  logic             greater;
  logic [CodeW:0]   diff;
  logic [DW-1:0]    rem_sh;
  logic             ge;
  logic [CodeW-1:0] quot;
  logic [CW-1:0]    div;
  logic [CW-1:0]    idx_inc;

  assign accept   = start && !busy;
  assign held_inc = held_q + CW'(1);
  assign greater  = $signed(rdata_q) > $signed(code_q);
  assign diff     = {rdata_q[CodeW-1], rdata_q} - {filt_q[CodeW-1], filt_q};
  assign div      = m_q - CW'(1);
  assign rem_sh   = {rem_q, dq_q[CodeW-1]};
  assign ge       = rem_sh >= {1'b0, div};
  assign quot     = {dq_q[CodeW-2:0], ge};
  assign idx_inc  = idx_q + CW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asf_pkg::StIdle: if (accept) state_d = asf_pkg::StIns;
      asf_pkg::StIns:  state_d = (pos_q == '0) ? asf_pkg::StPost : asf_pkg::StCmp;
      asf_pkg::StCmp:  state_d = greater ? asf_pkg::StIns : asf_pkg::StPost;
      asf_pkg::StPost: state_d = (held_inc < target) ? asf_pkg::StIdle : asf_pkg::StLo;
      asf_pkg::StLo:   state_d = asf_pkg::StHi;
      asf_pkg::StHi:   state_d = (m_q == CW'(1)) ? asf_pkg::StOut : asf_pkg::StFilt;
      asf_pkg::StFilt: begin
        state_d = (!filter_mode_q || m_q < CW'(4)) ? asf_pkg::StOut : asf_pkg::StAvg;
      end
      asf_pkg::StAvg:  state_d = asf_pkg::StDiv;
      asf_pkg::StDiv: begin
        if (bit_q == 4'd15) begin
          state_d = (idx_inc + CW'(1) < m_q) ? asf_pkg::StAvg : asf_pkg::StOut;
        end
      end
      asf_pkg::StOut:  state_d = asf_pkg::StIdle;
      default:         state_d = asf_pkg::StIdle;
    endcase
  end

  // Datapath and store control.
  always_comb begin
    held_d = held_q;
    m_d    = m_q;
    pos_d  = pos_q;
    idx_d  = idx_q;
    code_d = code_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    filt_d = filt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    bit_d  = bit_q;
    neg_d  = neg_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = pos_q;
    raddr  = pos_q - AW'(1);
    wdata  = code_q;
    unique case (state_q)
      asf_pkg::StIdle: begin
        if (accept) begin
          code_d = raw_sample_i;
          if (held_q >= CW'(MAX_SAMPLES)) begin
            held_d = '0;
            pos_d  = '0;
          end else begin
            pos_d = AW'(held_q);
          end
        end
      end
      asf_pkg::StIns: begin
        if (pos_q == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      asf_pkg::StCmp: begin
        mem_we = 1'b1;
        if (greater) begin
          wdata = rdata_q;
          pos_d = pos_q - AW'(1);
        end
      end
      asf_pkg::StPost: begin
        if (held_inc < target) begin
          held_d = held_inc;
        end else begin
          held_d = '0;
          m_d    = held_inc;
          mem_re = 1'b1;
          raddr  = '0;
        end
      end
      asf_pkg::StLo: begin
        lo_d   = rdata_q;
        mem_re = 1'b1;
        raddr  = AW'(m_q - CW'(1));
      end
      asf_pkg::StHi: begin
        hi_d   = rdata_q;
        filt_d = lo_q;
        mem_re = 1'b1;
        raddr  = filter_mode_q ? AW'(1) : AW'((m_q - CW'(1)) >> 1);
      end
      asf_pkg::StFilt: begin
        filt_d = rdata_q;
        idx_d  = CW'(2);
        mem_re = 1'b1;
        raddr  = AW'(2);
      end
      asf_pkg::StAvg: begin
        neg_d = diff[CodeW];
        dq_d  = diff[CodeW] ? CodeW'(-diff) : diff[CodeW-1:0];
        rem_d = '0;
        bit_d = '0;
      end
      asf_pkg::StDiv: begin
        rem_d = ge ? CW'(rem_sh - {1'b0, div}) : rem_sh[CW-1:0];
        dq_d  = quot;
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'd15) begin
          filt_d = neg_q ? filt_q - quot : filt_q + quot;
          idx_d  = idx_inc;
          mem_re = 1'b1;
          raddr  = AW'(idx_inc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asf_pkg::StIdle;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    code_q <= code_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    filt_q <= filt_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    neg_q  <= neg_d;
  end

  // Outputs.
  always_comb begin
    busy            = state_q != asf_pkg::StIdle;
    done_o          = state_q == asf_pkg::StOut;
    filtered_code_o = filt_q;
    min_code_o      = lo_q;
    max_code_o      = hi_q;
    voltage_o       = asf_pkg::to_volts(filt_q, gain_select_q);
    min_voltage_o   = asf_pkg::to_volts(lo_q, gain_select_q);
    max_voltage_o   = asf_pkg::to_volts(hi_q, gain_select_q);
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted sample did not raise busy");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(MAX_SAMPLES)) else $error("sample count out of range");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> held_q == '0) else $error("batch count not cleared at result");

endmodule

`default_nettype wire
